FILE: src/c3n_pkg.sv
// Shared types, constants and helper functions for the normalized 3x3 convolution.
// Used by the controller, the datapath and the top level.
package c3n_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_DW    = 33;
  localparam int CFG_IW    = 3;
  localparam int WT_BITS   = 11;
  localparam int WSUM_BITS = 15;
  localparam int IW_BITS   = 11;
  localparam int IH_BITS   = 16;
  localparam int MAC_TAPS  = 9;

  localparam logic [CFG_DW-1:0]  KERNEL_RESET = 33'd4196353;
  localparam logic [IW_BITS-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IH_BITS-1:0] HEIGHT_RESET = 16'd1024;

  typedef enum logic [CFG_IW-1:0] {
    CFG_KTOP   = 3'd0,
    CFG_KMID   = 3'd1,
    CFG_KBOT   = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic       accept;
    logic       update;
    logic       mac;
    logic [3:0] idx;
    logic       div_init;
    logic       div_step;
    logic       load_out;
  } c3n_cmd_t;

  typedef struct packed {
    logic produce;
    logic zero_sum;
  } c3n_sts_t;

  function automatic logic signed [WT_BITS-1:0] clamp_wt(input logic [WT_BITS-1:0] raw);
    logic signed [WT_BITS-1:0] w;
    w = signed'(raw);
    if (w > 11'sd999) begin
      return 11'sd999;
    end else if (w < -11'sd999) begin
      return -11'sd999;
    end
    return w;
  endfunction

endpackage

FILE: src/c3n_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module c3n_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/c3n_ctrl.sv
// Controller state machine: sequences line-store access, the nine MAC steps,
// the bit-serial divider and the output register. Uses c3n_pkg.
module c3n_ctrl
  import c3n_pkg::*;
#(
  parameter int QW = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  c3n_sts_t sts,
  output c3n_cmd_t cmd
);

  localparam int CW = $clog2(QW);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_DINIT = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.idx       = 4'(cnt_r);
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.update = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = sts.produce ? ST_MAC : ST_IDLE;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MAC_TAPS - 1)) begin
          state_nxt = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.zero_sum ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: src/c3n_dp.sv
// Datapath: line stores, window taps, position counters, one shared MAC,
// a restoring divider and the output register. Uses c3n_pkg and c3n_ram.
module c3n_dp
  import c3n_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int QW          = DEF_SAMPLE_BITS + 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  c3n_cmd_t                      cmd,
  output c3n_sts_t                      sts,
  input  logic [CFG_DW-1:0]             k_top,
  input  logic [CFG_DW-1:0]             k_mid,
  input  logic [CFG_DW-1:0]             k_bot,
  input  logic [IW_BITS-1:0]            w_eff,
  input  logic [IH_BITS-1:0]            h_eff,
  input  logic signed [SAMPLE_BITS-1:0] pixel_in,
  output logic signed [SAMPLE_BITS-1:0] pixel_out,
  output logic                          end_of_frame,
  output logic                          zero_weight_sum,
  output logic                          saturated
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int SB   = SAMPLE_BITS;
  localparam int ACCW = QW - 1;
  localparam int RW   = WSUM_BITS;

  logic [AW-1:0]              col_r;
  logic [IH_BITS-1:0]         row_r;
  logic signed [SB-1:0]       px_r;
  logic signed [SB-1:0]       tap_r [6];
  logic signed [SB-1:0]       nb_r [MAC_TAPS];
  logic [SB-1:0]              up_rd, mid_rd;
  logic signed [ACCW-1:0]     acc_r;
  logic signed [WSUM_BITS-1:0] wsum_r;
  logic [QW-1:0]              num_r, q_r;
  logic [RW-1:0]              den_r, rem_r;
  logic                       neg_r, zero_r, eof_r, eof_cur;
  logic                       end_col, end_row;
  logic signed [WT_BITS-1:0]  wsel;
  logic signed [SB+WT_BITS-1:0] prod;
  logic [ACCW-1:0]            n_abs;
  logic [WSUM_BITS-1:0]       d_abs;
  logic [RW:0]                rem2, rem2_sub;
  logic                       ge;
  logic signed [SB-1:0]       po;
  logic                       po_sat;
  logic signed [SB-1:0]       pixel_out_r;
  logic                       eof_out_r, zero_out_r, sat_out_r;

  c3n_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (col_r),
    .wr_data (mid_rd),
    .rd_en   (cmd.accept),
    .rd_addr (col_r),
    .rd_data (up_rd)
  );

  c3n_ram #(.WIDTH(SB), .DEPTH(MAX_WIDTH)) u_ram_middle (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (col_r),
    .wr_data (px_r),
    .rd_en   (cmd.accept),
    .rd_addr (col_r),
    .rd_data (mid_rd)
  );

  assign end_col = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign end_row = (17'(row_r) + 17'd1) >= 17'(h_eff);
  assign eof_cur = end_col && end_row;

  assign sts.produce  = (32'(col_r) >= 32'd2) && (row_r >= 16'd2);
  assign sts.zero_sum = (wsum_r == '0);

  always_comb begin
    unique case (cmd.idx)
      4'd0:    wsel = clamp_wt(k_top[10:0]);
      4'd1:    wsel = clamp_wt(k_top[21:11]);
      4'd2:    wsel = clamp_wt(k_top[32:22]);
      4'd3:    wsel = clamp_wt(k_mid[10:0]);
      4'd4:    wsel = clamp_wt(k_mid[21:11]);
      4'd5:    wsel = clamp_wt(k_mid[32:22]);
      4'd6:    wsel = clamp_wt(k_bot[10:0]);
      4'd7:    wsel = clamp_wt(k_bot[21:11]);
      4'd8:    wsel = clamp_wt(k_bot[32:22]);
      default: wsel = '0;
    endcase
  end

  assign prod  = wsel * nb_r[cmd.idx];
  assign n_abs = acc_r[ACCW-1] ? ACCW'(-acc_r) : ACCW'(acc_r);
  assign d_abs = wsum_r[WSUM_BITS-1] ? WSUM_BITS'(-wsum_r) : WSUM_BITS'(wsum_r);

  assign rem2     = {rem_r, num_r[QW-1]};
  assign rem2_sub = rem2 - {1'b0, den_r};
  assign ge       = rem2 >= {1'b0, den_r};

  always_comb begin
    po     = '0;
    po_sat = 1'b0;
    if (zero_r) begin
      po = '0;
    end else if (neg_r && (q_r != '0)) begin
      if (q_r > (QW'(1) << (SB - 1))) begin
        po_sat = 1'b1;
        po     = {1'b1, {(SB - 1){1'b0}}};
      end else begin
        po = SB'(~q_r + QW'(1));
      end
    end else begin
      if (q_r > QW'((64'd1 << (SB - 1)) - 64'd1)) begin
        po_sat = 1'b1;
        po     = {1'b0, {(SB - 1){1'b1}}};
      end else begin
        po = SB'(q_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        tap_r[i] <= '0;
      end
    end else if (cmd.update) begin
      tap_r[0] <= tap_r[3];
      tap_r[1] <= tap_r[4];
      tap_r[2] <= tap_r[5];
      tap_r[3] <= signed'(up_rd);
      tap_r[4] <= signed'(mid_rd);
      tap_r[5] <= px_r;
      if (end_col) begin
        col_r <= '0;
        row_r <= end_row ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r <= pixel_in;
    end
    if (cmd.update) begin
      nb_r[0] <= tap_r[0];
      nb_r[1] <= tap_r[3];
      nb_r[2] <= signed'(up_rd);
      nb_r[3] <= tap_r[1];
      nb_r[4] <= tap_r[4];
      nb_r[5] <= signed'(mid_rd);
      nb_r[6] <= tap_r[2];
      nb_r[7] <= tap_r[5];
      nb_r[8] <= px_r;
      eof_r   <= eof_cur;
      acc_r   <= '0;
      wsum_r  <= '0;
    end
    if (cmd.mac) begin
      acc_r  <= acc_r + ACCW'(prod);
      wsum_r <= wsum_r + WSUM_BITS'(wsel);
    end
    if (cmd.div_init) begin
      num_r  <= QW'({n_abs, 1'b0}) + QW'(d_abs);
      den_r  <= RW'({d_abs, 1'b0});
      rem_r  <= '0;
      q_r    <= '0;
      neg_r  <= acc_r[ACCW-1] != wsum_r[WSUM_BITS-1];
      zero_r <= (wsum_r == '0);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? RW'(rem2_sub) : RW'(rem2);
      q_r   <= {q_r[QW-2:0], ge};
      num_r <= num_r << 1;
    end
    if (cmd.load_out) begin
      pixel_out_r <= po;
      eof_out_r   <= eof_r;
      zero_out_r  <= zero_r;
      sat_out_r   <= po_sat;
    end
  end

  assign pixel_out       = pixel_out_r;
  assign end_of_frame    = eof_out_r;
  assign zero_weight_sum = zero_out_r;
  assign saturated       = sat_out_r;

endmodule

FILE: src/conv3x3_normalized.sv
// Top level of the normalized 3x3 convolution: configuration registers,
// controller and datapath. Uses c3n_pkg, c3n_ctrl and c3n_dp.
//
//   Channel  Ports                                   Beat
//   in       in_valid, in_ready, in_pixel_in         one raster sample
//   out      out_valid, out_ready, out_pixel_out,    one cropped result pixel
//            out_end_of_frame, out_zero_weight_sum, out_saturated
//   cfg      cfg_wr_en, cfg_index, cfg_data          one register write
//
// A beat that yields no result returns to idle after the line-store read. A beat
// that yields a result passes through the nine-step shared MAC and the
// one-bit-per-cycle restoring divider; a zero weight sum skips the divider.
// Reset is synchronous and clears control state, taps and counters; line stores
// are not cleared. A finished result waits in the output register while the next
// input beat is taken; the block stalls only when a second result is ready first.
module conv3x3_normalized
  import c3n_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_pixel_out,
  output logic                          out_end_of_frame,
  output logic                          out_zero_weight_sum,
  output logic                          out_saturated,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IW-1:0]             cfg_index,
  input  logic [CFG_DW-1:0]             cfg_data
);

  localparam int QW = SAMPLE_BITS + 16;

  logic [CFG_DW-1:0]  k_top_r, k_mid_r, k_bot_r;
  logic [IW_BITS-1:0] width_r, w_eff;
  logic [IH_BITS-1:0] height_r, h_eff;
  c3n_cmd_t           cmd;
  c3n_sts_t           sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r  <= KERNEL_RESET;
      k_mid_r  <= KERNEL_RESET;
      k_bot_r  <= KERNEL_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_KTOP)   k_top_r  <= cfg_data;
      if (cfg_index == CFG_KMID)   k_mid_r  <= cfg_data;
      if (cfg_index == CFG_KBOT)   k_bot_r  <= cfg_data;
      if (cfg_index == CFG_WIDTH)  width_r  <= cfg_data[IW_BITS-1:0];
      if (cfg_index == CFG_HEIGHT) height_r <= cfg_data[IH_BITS-1:0];
    end
  end

  always_comb begin
    if (width_r < 11'd3) begin
      w_eff = 11'd3;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = IW_BITS'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < 16'd3) ? 16'd3 : height_r;
  end

  c3n_ctrl #(.QW(QW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  c3n_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .QW          (QW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .k_top           (k_top_r),
    .k_mid           (k_mid_r),
    .k_bot           (k_bot_r),
    .w_eff           (w_eff),
    .h_eff           (h_eff),
    .pixel_in        (in_pixel_in),
    .pixel_out       (out_pixel_out),
    .end_of_frame    (out_end_of_frame),
    .zero_weight_sum (out_zero_weight_sum),
    .saturated       (out_saturated)
  );

  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in back-to-back cycles");

  a_zero_sum_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_weight_sum |-> (out_pixel_out == '0) && !out_saturated)
    else $error("zero weight sum with nonzero result or saturation");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_pixel_out == {1'b0, {(SAMPLE_BITS - 1){1'b1}}}) ||
      (out_pixel_out == {1'b1, {(SAMPLE_BITS - 1){1'b0}}}))
    else $error("saturated result not at a range limit");

endmodule
